/* rtl/mkd_pkg.sv */
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, register indexes and the Morse lookup for the key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int ElapsedWidth = 16;
  localparam int BufWidth     = 5;
  localparam int CountWidth   = 3;
  localparam int CharWidth    = 7;
  localparam int NodeWidth    = 6;
  localparam int CfgWidth     = 16;

  localparam logic [ElapsedWidth-1:0] ElapsedMax = '1;

  // configuration register indexes
  localparam logic REG_DOT_TICKS = 1'b0;
  localparam logic REG_GAP_TICKS = 1'b1;

  localparam logic [CfgWidth-1:0] DotTicksReset = 16'd15;
  localparam logic [CfgWidth-1:0] GapTicksReset = 16'd90;

  typedef struct packed {
    logic                    key_held;
    logic [ElapsedWidth-1:0] elapsed_ticks;
    logic [BufWidth-1:0]     symbol_bits;
    logic [CountWidth-1:0]   symbol_count;
  } state_t;

  typedef struct packed {
    logic                 symbol_event;
    logic                 symbol_is_dash;
    logic                 decode_event;
    logic                 char_valid;
    logic [CharWidth-1:0] character;
  } result_t;

  // walk the tree: root is node 1, a dit appends 0, a dash appends 1
  function automatic logic [NodeWidth-1:0] morse_node(
    input logic [BufWidth-1:0]   bits,
    input logic [CountWidth-1:0] count
  );
    logic [NodeWidth-1:0] node;
    node = NodeWidth'(1);
    for (int i = 0; i < BufWidth; i++) begin
      if (CountWidth'(i) < count) begin
        node = {node[NodeWidth-2:0], bits[i]};
      end
    end
    return node;
  endfunction

  // zero marks a node with no character
  function automatic logic [CharWidth-1:0] morse_char(input logic [NodeWidth-1:0] node);
    logic [CharWidth-1:0] ch;
    unique case (node)
      6'd2:    ch = 7'h45; // E
      6'd3:    ch = 7'h54; // T
      6'd4:    ch = 7'h49; // I
      6'd5:    ch = 7'h41; // A
      6'd6:    ch = 7'h4E; // N
      6'd7:    ch = 7'h4D; // M
      6'd8:    ch = 7'h53; // S
      6'd9:    ch = 7'h55; // U
      6'd10:   ch = 7'h52; // R
      6'd11:   ch = 7'h57; // W
      6'd12:   ch = 7'h44; // D
      6'd13:   ch = 7'h4B; // K
      6'd14:   ch = 7'h47; // G
      6'd15:   ch = 7'h4F; // O
      6'd16:   ch = 7'h48; // H
      6'd17:   ch = 7'h56; // V
      6'd18:   ch = 7'h46; // F
      6'd20:   ch = 7'h4C; // L
      6'd22:   ch = 7'h50; // P
      6'd23:   ch = 7'h4A; // J
      6'd24:   ch = 7'h42; // B
      6'd25:   ch = 7'h58; // X
      6'd26:   ch = 7'h43; // C
      6'd27:   ch = 7'h59; // Y
      6'd28:   ch = 7'h5A; // Z
      6'd29:   ch = 7'h51; // Q
      6'd32:   ch = 7'h35; // 5
      6'd33:   ch = 7'h34; // 4
      6'd35:   ch = 7'h33; // 3
      6'd39:   ch = 7'h32; // 2
      6'd42:   ch = 7'h2B; // +
      6'd47:   ch = 7'h31; // 1
      6'd48:   ch = 7'h36; // 6
      6'd49:   ch = 7'h3D; // =
      6'd50:   ch = 7'h2F; // /
      6'd56:   ch = 7'h37; // 7
      6'd60:   ch = 7'h38; // 8
      6'd62:   ch = 7'h39; // 9
      6'd63:   ch = 7'h30; // 0
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/mkd_step.sv */
// ----------------------------------------------------------------------------
// mkd_step
// One tick of the decoder: timing, symbol classification, buffer and decode.
// ----------------------------------------------------------------------------
module mkd_step #(
  parameter int MAX_SYMBOLS = 5
) (
  input  mkd_pkg::state_t                     state,
  input  logic                                key_pressed,
  input  logic [mkd_pkg::CfgWidth-1:0]        dot_ticks,
  input  logic [mkd_pkg::CfgWidth-1:0]        gap_ticks,
  output mkd_pkg::state_t                     state_next,
  output mkd_pkg::result_t                    result,
  output logic                                result_present
);
  import mkd_pkg::*;

  logic                    press;
  logic                    release_tick;
  logic                    dash;
  logic                    decode;
  logic [ElapsedWidth-1:0] elapsed_next;
  logic [BufWidth-1:0]     bits_app;
  logic [CountWidth-1:0]   count_app;
  logic [CharWidth-1:0]    ch;

  assign press        = key_pressed && !state.key_held;
  assign release_tick = !key_pressed && state.key_held;

  // counter saturates, restarts on a press
  always_comb begin
    if (press) begin
      elapsed_next = '0;
    end else if (state.elapsed_ticks != ElapsedMax) begin
      elapsed_next = state.elapsed_ticks + ElapsedWidth'(1);
    end else begin
      elapsed_next = state.elapsed_ticks;
    end
  end

  assign dash = (elapsed_next >= dot_ticks);

  always_comb begin
    bits_app  = state.symbol_bits;
    count_app = state.symbol_count;
    decode    = 1'b0;
    if (release_tick) begin
      bits_app  = state.symbol_bits | (BufWidth'(dash) << state.symbol_count);
      count_app = state.symbol_count + CountWidth'(1);
      decode    = (count_app >= CountWidth'(MAX_SYMBOLS));
    end else begin
      decode = (state.symbol_count != '0) && (elapsed_next > gap_ticks);
    end
  end

  assign ch = morse_char(morse_node(bits_app, count_app));

  always_comb begin
    state_next.key_held      = key_pressed;
    state_next.elapsed_ticks = elapsed_next;
    state_next.symbol_bits   = decode ? '0 : bits_app;
    state_next.symbol_count  = decode ? '0 : count_app;

    result.symbol_event   = release_tick;
    result.symbol_is_dash = release_tick && dash;
    result.decode_event   = decode;
    result.char_valid     = decode && (ch != '0);
    result.character      = decode ? ch : '0;
  end

  assign result_present = release_tick || decode;

endmodule

/* rtl/morse_key_decoder.sv */
// ----------------------------------------------------------------------------
// morse_key_decoder
// Morse key decoder: turns sampled key ticks into dits, dashes and characters.
// ----------------------------------------------------------------------------
// Each request is one timebase tick with the sampled key level. A tick is taken
// into an input register, processed in one pass against the key timing state
// and written to an output register. The block takes one request per clock
// while the output side keeps up. Ticks that append no symbol and decode
// nothing produce no result. dot_ticks and gap_ticks are to be written through
// the configuration port only while the block is idle; the block itself does
// not enforce this. They reset to 15 and 90.
module morse_key_decoder #(
  parameter int MAX_SYMBOLS = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [mkd_pkg::CfgWidth-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         key_pressed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         symbol_event,
  output logic                         symbol_is_dash,
  output logic                         decode_event,
  output logic                         char_valid,
  output logic [mkd_pkg::CharWidth-1:0] character
);
  import mkd_pkg::*;

  logic [CfgWidth-1:0] dot_ticks;
  logic [CfgWidth-1:0] gap_ticks;
  logic                in_held;
  logic                in_key;
  state_t              state;
  state_t              state_next;
  result_t             step_result;
  logic                step_present;
  result_t             result;
  logic                out_free;
  logic                advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks <= DotTicksReset;
      gap_ticks <= GapTicksReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOT_TICKS: dot_ticks <= cfg_data;
        REG_GAP_TICKS: gap_ticks <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign advance  = in_held && out_free;
  assign in_ready = !in_held || out_free;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_key <= key_pressed;
    end
  end

  mkd_step #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_step (
    .state          (state),
    .key_pressed    (in_key),
    .dot_ticks      (dot_ticks),
    .gap_ticks      (gap_ticks),
    .state_next     (state_next),
    .result         (step_result),
    .result_present (step_present)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && step_present;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_present) begin
      result <= step_result;
    end
  end

  assign symbol_event   = result.symbol_event;
  assign symbol_is_dash = result.symbol_is_dash;
  assign decode_event   = result.decode_event;
  assign char_valid     = result.char_valid;
  assign character      = result.character;

endmodule

/* rtl/morse_key_decoder_checker.sv */
// ----------------------------------------------------------------------------
// morse_key_decoder_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module morse_key_decoder_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          symbol_event,
  input logic                          symbol_is_dash,
  input logic                          decode_event,
  input logic                          char_valid,
  input logic [mkd_pkg::CharWidth-1:0] character
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol_event) &&
      $stable(symbol_is_dash) && $stable(decode_event) && $stable(char_valid) &&
      $stable(character))
    else $error("result changed while stalled");

  // every result carries a symbol or a decode
  a_has_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> symbol_event || decode_event)
    else $error("result without an event");

  a_no_decode: assert property (@(posedge clk) disable iff (rst)
    out_valid && !decode_event |-> !char_valid && character == '0)
    else $error("character reported without a decode");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> character == '0)
    else $error("invalid decode with nonzero character");

  a_no_symbol: assert property (@(posedge clk) disable iff (rst)
    out_valid && !symbol_event |-> !symbol_is_dash)
    else $error("dash flag without a symbol");

endmodule

bind morse_key_decoder morse_key_decoder_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .symbol_event   (symbol_event),
  .symbol_is_dash (symbol_is_dash),
  .decode_event   (decode_event),
  .char_valid     (char_valid),
  .character      (character)
);
